### rtl/core/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg: shared types and constants for the arctangent block
// Holds the classification flags, the Q2.30 coefficient table and the angle
// constants used by the front end, the queue and the evaluation pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int RATIO_W  = 32;
  localparam int VAL_W    = 36;
  localparam int COEF_W   = 32;
  localparam int DEGREE   = 6;
  localparam int SEGMENTS = 8;
  localparam int SEG_W    = $clog2(SEGMENTS);
  localparam int ANGLE_W  = 31;
  localparam int INT_FRAC = 30;

  localparam logic signed [VAL_W-1:0] Q30_PI_4 = 36'sd843314857;
  localparam logic signed [VAL_W-1:0] Q30_PI_2 = 36'sd1686629713;
  localparam logic signed [VAL_W-1:0] Q30_PI   = 36'sd3373259426;

  typedef struct packed {
    logic zero;
    logic eq;
    logic swap;
    logic neg_x;
    logic neg_y;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

  function automatic logic signed [COEF_W-1:0] coef(input logic [SEG_W-1:0] seg,
                                                    input logic [2:0] k);
    logic signed [COEF_W-1:0] c [0:DEGREE];
    unique case (seg)
      3'd0: c = '{0, 1073741826, -281, -357897744, -459607, 221580279, -51149363};
      3'd1: c = '{-118, 1073747823, -130406, -356339388, -11463126, 265547244,
                  -129390110};
      3'd2: c = '{-465, 1073761643, -347741, -354571685, -19401292, 284340708,
                  -147795649};
      3'd3: c = '{39893, 1073011554, 5486503, -378891465, 37925923, 211854692,
                  -109371513};
      3'd4: c = '{394273, 1068016510, 34946714, -471970575, 204107086, 52870331,
                  -45692560};
      3'd5: c = '{1651639, 1054067081, 99652562, -632612564, 429242040, -116009145,
                  7279372};
      3'd6: c = '{3545127, 1036945327, 164333678, -763273858, 578096349, -206681063,
                  30349077};
      default: c = '{2239932, 1045682080, 140095915, -727645053, 548873060,
                     -194026385, 28095309};
    endcase
    return (k > 3'(DEGREE)) ? c[DEGREE] : c[k];
  endfunction

endpackage

### rtl/core/atp_front.sv
// ----------------------------------------------------------------------------
// atp_front: coordinate classification
// Takes magnitudes of both coordinates, orders them and sets the octant flags.
// ----------------------------------------------------------------------------
module atp_front import atp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic [31:0]            coord_y,
  input  logic [31:0]            coord_x,
  output flags_t                 flags,
  output logic [COORD_WIDTH-1:0] mag_lo,
  output logic [COORD_WIDTH-1:0] mag_hi
);

  logic [COORD_WIDTH-1:0] ry, rx, ay, ax;

  always_comb begin
    ry = coord_y[COORD_WIDTH-1:0];
    rx = coord_x[COORD_WIDTH-1:0];
    // The most negative value negates to itself, which reads as the exact magnitude.
    ay = ry[COORD_WIDTH-1] ? (~ry + 1'b1) : ry;
    ax = rx[COORD_WIDTH-1] ? (~rx + 1'b1) : rx;
    flags.neg_y = ry[COORD_WIDTH-1];
    flags.neg_x = rx[COORD_WIDTH-1];
    flags.zero  = (ay == '0) && (ax == '0);
    flags.eq    = (ay == ax);
    flags.swap  = (ay > ax);
    mag_lo = flags.swap ? ax : ay;
    mag_hi = flags.swap ? ay : ax;
  end

endmodule

### rtl/core/atp_fifo.sv
// ----------------------------------------------------------------------------
// atp_fifo: short queue between front end and evaluation pipeline
// Register-based, first-word fall-through on the read side.
// ----------------------------------------------------------------------------
module atp_fifo #(
  parameter int DATA_W = 69,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;
  logic              do_w, do_r;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_w  = we && !full;
  assign do_r  = re && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_w) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_w) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_r) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(do_w) - CNT_W'(do_r);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

### rtl/core/atp_div.sv
// ----------------------------------------------------------------------------
// atp_div: pipelined ratio divider
// Restoring division, one quotient bit per stage, giving small/large in Q0.32.
// ----------------------------------------------------------------------------
module atp_div import atp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  flags_t                 in_flags,
  input  logic [COORD_WIDTH-1:0] in_small,
  input  logic [COORD_WIDTH-1:0] in_large,
  output logic                   out_valid,
  output flags_t                 out_flags,
  output logic [RATIO_W-1:0]     out_ratio
);

  logic                   sv  [0:RATIO_W];
  flags_t                 sf  [0:RATIO_W];
  logic [COORD_WIDTH-1:0] rem [0:RATIO_W];
  logic [COORD_WIDTH-1:0] den [0:RATIO_W];
  logic [RATIO_W-1:0]     quo [0:RATIO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf[0]  <= in_flags;
      rem[0] <= in_small;
      den[0] <= in_large;
      quo[0] <= '0;
    end
  end

  for (genvar i = 0; i < RATIO_W; i++) begin : g_step
    logic [COORD_WIDTH:0] t;
    logic [COORD_WIDTH:0] d;
    logic                 ge;

    assign t  = {rem[i], 1'b0};
    assign d  = t - {1'b0, den[i]};
    assign ge = (t >= {1'b0, den[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sf[i+1]  <= sf[i];
        den[i+1] <= den[i];
        rem[i+1] <= ge ? d[COORD_WIDTH-1:0] : t[COORD_WIDTH-1:0];
        quo[i+1] <= {quo[i][RATIO_W-2:0], ge};
      end
    end
  end

  assign out_valid = sv[RATIO_W];
  assign out_flags = sf[RATIO_W];
  assign out_ratio = quo[RATIO_W];

endmodule

### rtl/core/atp_horner.sv
// ----------------------------------------------------------------------------
// atp_horner: piecewise polynomial evaluation
// Degree-6 Horner scheme, each step split into a multiply and a round-add stage.
// ----------------------------------------------------------------------------
module atp_horner import atp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  flags_t                  in_flags,
  input  logic [RATIO_W-1:0]      in_ratio,
  output logic                    out_valid,
  output flags_t                  out_flags,
  output logic signed [VAL_W-1:0] out_val
);

  logic                    hv [0:DEGREE];
  flags_t                  hf [0:DEGREE];
  logic [RATIO_W-1:0]      hr [0:DEGREE];
  logic signed [VAL_W-1:0] hx [0:DEGREE];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (en) begin
      hv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hf[0] <= in_flags;
      hr[0] <= in_ratio;
      hx[0] <= VAL_W'(coef(in_ratio[RATIO_W-1 -: SEG_W], 3'(DEGREE)));
    end
  end

  for (genvar j = 0; j < DEGREE; j++) begin : g_step
    localparam logic [2:0] K = 3'(DEGREE - 1 - j);

    logic                     mv;
    flags_t                   mf;
    logic [RATIO_W-1:0]       mr;
    logic                     mneg;
    logic [2*RATIO_W-1:0]     mprod;
    logic [VAL_W-1:0]         mag;
    logic [RATIO_W-1:0]       clamp;
    logic [2*RATIO_W-1:0]     rnd;
    logic [RATIO_W-1:0]       q;
    logic signed [VAL_W-1:0]  sq;

    always_comb begin
      mag   = hx[j][VAL_W-1] ? VAL_W'(-hx[j]) : hx[j];
      // Magnitude is limited to 32 bits ahead of the multiply.
      clamp = (mag[VAL_W-1:RATIO_W] != '0) ? '1 : mag[RATIO_W-1:0];
      rnd   = mprod + (2*RATIO_W)'(64'h8000_0000);
      q     = rnd[2*RATIO_W-1:RATIO_W];
      sq    = mneg ? -$signed({4'b0, q}) : $signed({4'b0, q});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv      <= 1'b0;
        hv[j+1] <= 1'b0;
      end else if (en) begin
        mv      <= hv[j];
        hv[j+1] <= mv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mf      <= hf[j];
        mr      <= hr[j];
        mneg    <= hx[j][VAL_W-1];
        mprod   <= clamp * hr[j];
        hf[j+1] <= mf;
        hr[j+1] <= mr;
        hx[j+1] <= sq + VAL_W'(coef(mr[RATIO_W-1 -: SEG_W], K));
      end
    end
  end

  assign out_valid = hv[DEGREE];
  assign out_flags = hf[DEGREE];
  assign out_val   = hx[DEGREE];

endmodule

### rtl/core/atan2_piecewise_poly.sv
// An accepted push reaches the head through the queue and then, behind the queue,
// a 33-stage divider, a 13-stage polynomial and 2 fold stages.
// Throughput: one transaction per cycle while pop is high or no result is held;
// every divider bit and Horner step has its own stage, so each unit holds one item per cycle.
// Reset: rst clears the queue and all valid bits; empty is high after reset.
// Output is held while empty is low and pop is low; the whole back end stalls.
// ----------------------------------------------------------------------------
// atan2_piecewise_poly: four-quadrant arctangent, top level
// Front end classifies, a queue decouples it from the evaluation pipeline,
// and the fold stages map the first-octant angle to the full circle.
// ----------------------------------------------------------------------------
module atan2_piecewise_poly import atp_pkg::*; #(
  parameter int COORD_WIDTH         = 32,
  parameter int ANGLE_FRACTION_BITS = 28
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [31:0]        coord_y,
  input  logic signed [31:0]        coord_x,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int SHIFT  = INT_FRAC - ANGLE_FRACTION_BITS;
  localparam int QDATA  = FLAGS_W + 2*COORD_WIDTH;
  localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (SHIFT - 1);
  localparam logic [VAL_W-1:0] PI_OUT = (VAL_W'(Q30_PI) + HALF) >> SHIFT;

  flags_t                   f_flags;
  logic [COORD_WIDTH-1:0]   f_small, f_large;
  logic [QDATA-1:0]         q_rdata;
  logic                     q_empty, q_re, en;
  logic                     d_valid, h_valid;
  flags_t                   d_flags, h_flags;
  logic [RATIO_W-1:0]       d_ratio;
  logic signed [VAL_W-1:0]  h_val;

  logic                     p_valid, p_neg;
  logic signed [VAL_W-1:0]  p_val, fold, fold_x;
  logic                     out_valid;
  logic [VAL_W-1:0]         mag, mag_r;
  logic signed [ANGLE_W-1:0] res;

  assign en    = !out_valid || pop;
  assign q_re  = en && !q_empty;
  assign empty = !out_valid;

  atp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .coord_y (coord_y),
    .coord_x (coord_x),
    .flags   (f_flags),
    .mag_lo  (f_small),
    .mag_hi  (f_large)
  );

  atp_fifo #(.DATA_W(QDATA), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .we    (push),
    .wdata ({f_flags, f_small, f_large}),
    .re    (q_re),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  atp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_re),
    .in_flags  (q_rdata[QDATA-1 -: FLAGS_W]),
    .in_small  (q_rdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_large  (q_rdata[COORD_WIDTH-1:0]),
    .out_valid (d_valid),
    .out_flags (d_flags),
    .out_ratio (d_ratio)
  );

  atp_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_flags  (d_flags),
    .in_ratio  (d_ratio),
    .out_valid (h_valid),
    .out_flags (h_flags),
    .out_val   (h_val)
  );

  always_comb begin
    priority if (h_flags.zero) begin
      fold = '0;
    end else if (h_flags.eq) begin
      fold = Q30_PI_4;
    end else if (h_flags.swap) begin
      fold = Q30_PI_2 - h_val;
    end else begin
      fold = h_val;
    end
    fold_x = (h_flags.neg_x && !h_flags.zero) ? Q30_PI - fold : fold;
  end

  // Rounding is symmetric about zero, so the y sign is applied after it.
  always_comb begin
    mag   = p_val[VAL_W-1] ? VAL_W'(-p_val) : p_val;
    mag_r = (mag + HALF) >> SHIFT;
    res   = (p_val[VAL_W-1] ^ p_neg) ? -$signed(mag_r[ANGLE_W-1:0])
                                     : $signed(mag_r[ANGLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= h_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_val <= fold_x;
      p_neg <= h_flags.neg_y && !h_flags.zero;
      angle <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> ($signed(VAL_W'(angle)) <= $signed(PI_OUT) &&
                  $signed(VAL_W'(angle)) >= -$signed(PI_OUT)))
    else $error("angle outside of minus pi to pi");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");
`endif

endmodule
